// ===== rtl/core/ascii_rtcm3_frame_detector_core_defines.svh =====
// assertion macros shared by the frame detector rtl
`ifndef ASCII_RTCM3_FRAME_DETECTOR_CORE_DEFINES_SVH
`define ASCII_RTCM3_FRAME_DETECTOR_CORE_DEFINES_SVH

// same-cycle check on clk, off while arst_n is low
`define ARFD_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// next-cycle check on clk, off while arst_n is low
`define ARFD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/arfd_pkg.sv =====
// types, constants and the crc-24q byte update for the frame detector
package arfd_pkg;

	localparam int BYTE_W  = 8;
	localparam int INDEX_W = 11;
	localparam int TYPE_W  = 12;
	localparam int SUB_W   = 4;
	localparam int MARKS_W = 6;
	localparam int LEN_W   = 10;
	localparam int CRC_W   = 24;
	localparam int HDR_W   = 32;

	localparam logic [BYTE_W-1:0] START_RTCM = 8'hD3;
	localparam logic [BYTE_W-1:0] CHR_HASH   = 8'h23;
	localparam logic [BYTE_W-1:0] CHR_A      = 8'h41;
	localparam logic [BYTE_W-1:0] CHR_P      = 8'h50;
	localparam logic [BYTE_W-1:0] CHR_STAR   = 8'h2A;
	localparam logic [BYTE_W-1:0] CHR_COMMA  = 8'h2C;
	localparam logic [BYTE_W-1:0] CHR_CR     = 8'h0D;
	localparam logic [BYTE_W-1:0] CHR_LF     = 8'h0A;

	// low 24 bits of 0x1864CFB, top bit is the shifted-out bit
	localparam logic [CRC_W-1:0]  CRC_POLY        = 24'h864CFB;
	localparam logic [TYPE_W-1:0] VENDOR_TYPE_RST = 12'd4058;

	// header bytes before the crc-covered payload ends, and total framing bytes
	localparam int RTCM_HDR_LEN  = 3;
	localparam int RTCM_OVERHEAD = 6;

	typedef enum logic [1:0] {
		DONE_NONE  = 2'd0,
		DONE_ASCII = 2'd1,
		DONE_RTCM  = 2'd2
	} done_t;

	typedef struct packed {
		done_t              frame_done;
		logic               byte_kept;
		logic [INDEX_W-1:0] byte_index;
		logic               crc_fail;
		logic [TYPE_W-1:0]  msg_type;
		logic [SUB_W-1:0]   msg_subtype;
		logic [MARKS_W-1:0] field_marks;
	} result_t;

	function automatic logic [CRC_W-1:0] crc24q_byte(input logic [CRC_W-1:0] crc,
			input logic [BYTE_W-1:0] b);
		logic [CRC_W-1:0] c;
		c = crc ^ {b, 16'h0000};
		for (int k = 0; k < BYTE_W; k++) begin
			c = c[CRC_W-1] ? ({c[CRC_W-2:0], 1'b0} ^ CRC_POLY) : {c[CRC_W-2:0], 1'b0};
		end
		return c;
	endfunction

endpackage

// ===== rtl/core/arfd_if.sv =====
// valid/ready channels of the frame detector: input byte, result, configuration
interface arfd_byte_if import arfd_pkg::*;;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface arfd_result_if import arfd_pkg::*;;
	logic               valid;
	logic               ready;
	logic [1:0]         frame_done;
	logic               byte_kept;
	logic [INDEX_W-1:0] byte_index;
	logic               crc_fail;
	logic [TYPE_W-1:0]  msg_type;
	logic [SUB_W-1:0]   msg_subtype;
	logic [MARKS_W-1:0] field_marks;

	modport source (output valid, output frame_done, output byte_kept, output byte_index,
		output crc_fail, output msg_type, output msg_subtype, output field_marks,
		input ready);
	modport sink (input valid, input frame_done, input byte_kept, input byte_index,
		input crc_fail, input msg_type, input msg_subtype, input field_marks,
		output ready);
endinterface

interface arfd_cfg_if import arfd_pkg::*;;
	logic              valid;
	logic              ready;
	logic [TYPE_W-1:0] vendor_msg_type;

	modport source (output valid, output vendor_msg_type, input ready);
	modport sink (input valid, input vendor_msg_type, output ready);
endinterface

// ===== rtl/core/ascii_rtcm3_frame_detector_core.sv =====
// frame detector top level: "#AP" ascii sentences and rtcm3 frames with crc-24q check
//
// Takes one received byte per transfer on rx and returns exactly one result per byte on
// result. Each byte is captured in an input register, classified by one pass of
// combinational logic (start checks, header capture, one byte of crc-24q, end-of-frame
// tests) and written to a result register, so a new byte is taken every cycle; the only
// stall comes from result.ready.
// The vendor message type register (reset 4058) is written on cfg and should change
// only while no byte is in flight. An ascii sentence starts with "#AP" and ends on CR
// or LF when '*' lies three bytes back; an rtcm3 frame starts with 0xD3 and ends after
// its length plus six bytes. A frame that reaches BUFFER_BYTES bytes is abandoned.
`include "ascii_rtcm3_frame_detector_core_defines.svh"

module ascii_rtcm3_frame_detector_core import arfd_pkg::*; #(
	parameter int BUFFER_BYTES   = 2048,
	parameter int MAX_SEPARATORS = 63
) (
	input  logic          clk,
	input  logic          arst_n,
	arfd_byte_if.sink     rx,
	arfd_result_if.source result,
	arfd_cfg_if.sink      cfg
);

	localparam int CNT_W = $clog2(BUFFER_BYTES + 1);
	localparam int SEP_W = $clog2(MAX_SEPARATORS + 1);

	// input stage
	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	// result stage
	logic              valid_s2;
	result_t           res_s2;

	// frame state
	logic [TYPE_W-1:0] vendor_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [BYTE_W-1:0] start_q;
	logic [HDR_W-1:0]  header_q;
	logic [CRC_W-1:0]  crc_q;
	logic [CRC_W-1:0]  parity_q;
	logic [HDR_W-1:0]  recent_q;
	logic [SEP_W-1:0]  sep_q;

	logic advance;

	// next-state and result of the single pass
	logic [CNT_W-1:0]  cnt;
	logic              start_hit;
	logic              is_rtcm;
	logic              kept;
	logic [BYTE_W-1:0] start_b;
	logic [HDR_W-1:0]  header_b;
	logic [CRC_W-1:0]  crc_b;
	logic [CRC_W-1:0]  parity_b;
	logic [HDR_W-1:0]  recent_b;
	logic [SEP_W-1:0]  sep_b;
	logic [HDR_W-1:0]  header_k;
	logic [CRC_W-1:0]  crc_k;
	logic [CRC_W-1:0]  parity_k;
	logic [HDR_W-1:0]  recent_k;
	logic [SEP_W-1:0]  sep_k;
	logic [CNT_W-1:0]  cnt_k;
	logic [CNT_W-1:0]  cnt_n;
	logic [CNT_W-1:0]  len_old;
	logic [CNT_W-1:0]  len_new;
	logic              ascii_end;
	logic              bump;
	logic [SEP_W+MARKS_W-1:0] sep_ext;
	result_t           res_c;

	assign advance  = valid_s1 && (!valid_s2 || result.ready);
	assign rx.ready = !valid_s1 || advance;
	assign cfg.ready = 1'b1;

	always_comb begin
		cnt = (cnt_q >= CNT_W'(BUFFER_BYTES)) ? '0 : cnt_q;
		start_hit = (cnt == '0) && (byte_s1 == CHR_HASH || byte_s1 == START_RTCM);

		// a valid start clears the frame before the start byte goes in
		start_b  = start_hit ? byte_s1 : start_q;
		header_b = start_hit ? '0 : header_q;
		crc_b    = start_hit ? '0 : crc_q;
		parity_b = start_hit ? '0 : parity_q;
		recent_b = start_hit ? '0 : recent_q;
		sep_b    = start_hit ? '0 : sep_q;
		is_rtcm  = (start_b == START_RTCM);

		if (cnt == '0) begin
			kept = start_hit;
		end else if (cnt < CNT_W'(RTCM_HDR_LEN)) begin
			kept = is_rtcm || ((cnt == CNT_W'(1)) ? (byte_s1 == CHR_A) : (byte_s1 == CHR_P));
		end else begin
			kept = 1'b1;
		end

		// header holds frame bytes one to four, byte one on top
		header_k = header_b;
		for (int i = 1; i <= 4; i++) begin
			if (cnt == CNT_W'(i)) begin
				header_k[BYTE_W*(4-i) +: BYTE_W] = header_b[BYTE_W*(4-i) +: BYTE_W] | byte_s1;
			end
		end
		len_old = CNT_W'(header_b[16 +: LEN_W]);
		len_new = CNT_W'(header_k[16 +: LEN_W]);
		crc_k = (cnt < CNT_W'(RTCM_HDR_LEN) || cnt < len_old + CNT_W'(RTCM_HDR_LEN)) ?
			crc24q_byte(crc_b, byte_s1) : crc_b;
		parity_k = {parity_b[CRC_W-BYTE_W-1:0], byte_s1};
		recent_k = {recent_b[HDR_W-BYTE_W-1:0], byte_s1};
		cnt_k    = cnt + CNT_W'(1);

		// ascii end: CR or LF with the checksum mark three bytes back
		ascii_end = (byte_s1 == CHR_CR || byte_s1 == CHR_LF) &&
			(recent_k[HDR_W-1 -: BYTE_W] == CHR_STAR);
		bump = !is_rtcm && (cnt >= CNT_W'(RTCM_HDR_LEN)) &&
			(byte_s1 == CHR_COMMA || ascii_end);
		sep_k = (bump && sep_b < SEP_W'(MAX_SEPARATORS)) ? sep_b + SEP_W'(1) : sep_b;

		res_c = '0;
		res_c.byte_kept = kept;
		if (kept) begin
			res_c.byte_index = cnt[INDEX_W-1:0];
		end
		if (cnt >= CNT_W'(RTCM_HDR_LEN)) begin
			if (!is_rtcm) begin
				if (ascii_end) begin
					res_c.frame_done = DONE_ASCII;
				end
			end else if (cnt_k >= len_new + CNT_W'(RTCM_OVERHEAD)) begin
				res_c.frame_done = DONE_RTCM;
				res_c.msg_type   = header_k[4 +: TYPE_W];
				res_c.crc_fail   = (crc_k != parity_k);
				if (crc_k == parity_k && header_k[4 +: TYPE_W] == vendor_q) begin
					res_c.msg_subtype = header_k[SUB_W-1:0];
				end
			end
		end
		sep_ext = {{MARKS_W{1'b0}}, sep_k};
		if (kept && !is_rtcm) begin
			res_c.field_marks = sep_ext[MARKS_W-1:0];
		end

		cnt_n = (kept && res_c.frame_done == DONE_NONE) ? cnt_k : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			byte_s1 <= rx.rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (result.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vendor_q <= VENDOR_TYPE_RST;
		end else if (cfg.valid) begin
			vendor_q <= cfg.vendor_msg_type;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			start_q  <= '0;
			header_q <= '0;
			crc_q    <= '0;
			parity_q <= '0;
			recent_q <= '0;
			sep_q    <= '0;
		end else if (advance) begin
			cnt_q <= cnt_n;
			if (kept) begin
				start_q  <= start_b;
				header_q <= header_k;
				crc_q    <= crc_k;
				parity_q <= parity_k;
				recent_q <= recent_k;
				sep_q    <= sep_k;
			end
		end
	end

	assign result.valid       = valid_s2;
	assign result.frame_done  = res_s2.frame_done;
	assign result.byte_kept   = res_s2.byte_kept;
	assign result.byte_index  = res_s2.byte_index;
	assign result.crc_fail    = res_s2.crc_fail;
	assign result.msg_type    = res_s2.msg_type;
	assign result.msg_subtype = res_s2.msg_subtype;
	assign result.field_marks = res_s2.field_marks;

	`ARFD_ASSERT(a_done_kept, !valid_s2 || res_s2.frame_done == DONE_NONE || res_s2.byte_kept, "completed frame on a dropped byte")
	`ARFD_ASSERT(a_rtcm_fields, !valid_s2 || res_s2.frame_done == DONE_RTCM || (res_s2.msg_type == '0 && res_s2.msg_subtype == '0 && !res_s2.crc_fail), "rtcm fields set outside an rtcm completion")
	`ARFD_ASSERT(a_drop_quiet, !valid_s2 || res_s2.byte_kept || (res_s2.byte_index == '0 && res_s2.field_marks == '0), "index or marks on a dropped byte")
	`ARFD_ASSERT(a_subtype_ok, !valid_s2 || res_s2.msg_subtype == '0 || (res_s2.frame_done == DONE_RTCM && !res_s2.crc_fail), "subtype without a clean rtcm frame")
	`ARFD_ASSERT_NEXT(a_count_restart, advance && res_c.frame_done != DONE_NONE, cnt_q == '0, "count not cleared after a completed frame")

endmodule

// ===== tb/sv/tb_ascii_rtcm3_frame_detector_core.sv =====
// testbench for the ascii / rtcm3 frame detector: directed frames, random traffic, checker
`timescale 1ns / 100ps

import arfd_pkg::*;

localparam int FRAME_BUFFER_BYTES = 2048;
localparam int SEPARATOR_LIMIT    = 63;

// one byte of crc-24q, msb first, kept in 25 bits so the carry can be tested
function automatic logic [23:0] crc24q_next(input logic [23:0] c, input logic [7:0] b);
	logic [24:0] acc;
	int k;
	acc = {1'b0, c ^ {b, 16'h0000}};
	for (k = 0; k < 8; k++) begin
		acc = acc << 1;
		if (acc[24])
			acc = acc ^ 25'h1864CFB;
	end
	return acc[23:0];
endfunction

class frame_tracker;
	logic [11:0] vendor_type;
	int unsigned held;
	logic [7:0]  first_byte;
	logic [31:0] hdr;
	logic [23:0] crc_acc;
	logic [23:0] tail3;
	logic [31:0] last4;
	int unsigned seps;
	result_t     due_results[$];
	int unsigned mismatches;

	function new();
		vendor_type = VENDOR_TYPE_RST;
		mismatches  = 0;
		clear();
	endfunction

	function void clear();
		held       = 0;
		first_byte = '0;
		hdr        = '0;
		crc_acc    = '0;
		tail3      = '0;
		last4      = '0;
		seps       = 0;
	endfunction

	function void bump();
		if (seps < SEPARATOR_LIMIT)
			seps++;
	endfunction

	// store a kept byte at position held
	function void append(input logic [7:0] b);
		int unsigned flen;
		flen = hdr[25:16];
		if (held >= 1 && held <= 4)
			hdr = hdr | (32'(b) << (8 * (4 - held)));
		if (held < 3 || held < flen + 3)
			crc_acc = crc24q_next(crc_acc, b);
		tail3 = {tail3[15:0], b};
		last4 = {last4[23:0], b};
		held++;
	endfunction

	function void note_byte(input logic [7:0] b);
		result_t r;
		int unsigned flen;
		r = '0;
		if (held >= FRAME_BUFFER_BYTES)
			held = 0;
		if (held == 0) begin
			if (b == CHR_HASH || b == START_RTCM) begin
				clear();
				first_byte = b;
				append(b);
				r.byte_kept = 1'b1;
			end
		end else if (held < 3) begin
			if (first_byte == START_RTCM || (held == 1 ? b == CHR_A : b == CHR_P)) begin
				r.byte_index = 11'(held);
				append(b);
				r.byte_kept = 1'b1;
			end else begin
				held = 0;
			end
		end else begin
			r.byte_index = 11'(held);
			r.byte_kept  = 1'b1;
			if (first_byte != START_RTCM) begin
				if (b == CHR_COMMA)
					bump();
				append(b);
				// the checksum mark must sit three bytes before the line end
				if ((b == CHR_CR || b == CHR_LF) && last4[31:24] == CHR_STAR) begin
					bump();
					r.frame_done = DONE_ASCII;
				end
			end else begin
				append(b);
				flen = hdr[25:16];
				if (held >= flen + 6) begin
					r.msg_type   = hdr[15:4];
					r.crc_fail   = (crc_acc != tail3);
					if (!r.crc_fail && r.msg_type == vendor_type)
						r.msg_subtype = hdr[3:0];
					r.frame_done = DONE_RTCM;
				end
			end
		end
		if (r.byte_kept && first_byte != START_RTCM)
			r.field_marks = 6'(seps);
		if (r.frame_done != DONE_NONE)
			held = 0;
		due_results.push_back(r);
	endfunction

	function string show(input result_t r);
		return $sformatf("done %0d kept %0d idx %0d fail %0d type %0d sub %0d marks %0d",
			r.frame_done, r.byte_kept, r.byte_index, r.crc_fail, r.msg_type,
			r.msg_subtype, r.field_marks);
	endfunction

	function void check_result(input result_t got);
		result_t want;
		if (due_results.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected result: %s", show(got));
			return;
		end
		want = due_results.pop_front();
		if (got.frame_done !== want.frame_done || got.byte_kept !== want.byte_kept ||
				got.byte_index !== want.byte_index || got.crc_fail !== want.crc_fail ||
				got.msg_type !== want.msg_type || got.msg_subtype !== want.msg_subtype ||
				got.field_marks !== want.field_marks) begin
			mismatches++;
			if (mismatches <= 10)
				$display("result mismatch: expected %s, got %s", show(want), show(got));
		end
	endfunction
endclass

module tb_ascii_rtcm3_frame_detector_core;

	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASE_BYTES = 340;

	logic clk;
	logic arst_n;

	arfd_byte_if   rx_ch ();
	arfd_result_if res_ch ();
	arfd_cfg_if    cfg_ch ();

	ascii_rtcm3_frame_detector_core #(
		.BUFFER_BYTES   (FRAME_BUFFER_BYTES),
		.MAX_SEPARATORS (SEPARATOR_LIMIT)
	) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_ch),
		.result (res_ch),
		.cfg    (cfg_ch)
	);

	frame_tracker board = new();
	bit           gaps_on;
	int unsigned  cycles;
	int unsigned  bytes_sent;
	logic [11:0]  vendor_now;
	result_t      got;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(negedge clk) begin
		res_ch.ready = !gaps_on || ($urandom_range(99) >= 15);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			cycles++;
			if (cfg_ch.valid && cfg_ch.ready)
				board.vendor_type = cfg_ch.vendor_msg_type;
			if (rx_ch.valid && rx_ch.ready)
				board.note_byte(rx_ch.rx_byte);
			if (res_ch.valid && res_ch.ready) begin
				got.frame_done  = done_t'(res_ch.frame_done);
				got.byte_kept   = res_ch.byte_kept;
				got.byte_index  = res_ch.byte_index;
				got.crc_fail    = res_ch.crc_fail;
				got.msg_type    = res_ch.msg_type;
				got.msg_subtype = res_ch.msg_subtype;
				got.field_marks = res_ch.field_marks;
				board.check_result(got);
			end
			if (cycles > CYCLE_LIMIT) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	// called and returns at a falling edge; valid stays high for a following byte
	task automatic send_byte(input logic [7:0] b);
		while (gaps_on && $urandom_range(99) < 15) begin
			rx_ch.valid = 1'b0;
			@(negedge clk);
		end
		rx_ch.valid   = 1'b1;
		rx_ch.rx_byte = b;
		do @(posedge clk); while (!rx_ch.ready);
		bytes_sent++;
		@(negedge clk);
	endtask

	task automatic send_text(input string s);
		int i;
		for (i = 0; i < s.len(); i++)
			send_byte(s[i]);
	endtask

	// cut drops that many bytes from the end, so later traffic completes the frame
	task automatic send_rtcm(input int unsigned len, input logic [11:0] mtype,
			input logic [3:0] sub, input bit spoil, input int unsigned cut);
		logic [7:0]  fr[$];
		logic [23:0] c;
		int unsigned i;
		fr.push_back(START_RTCM);
		fr.push_back({6'($urandom), 2'(len >> 8)});
		fr.push_back(8'(len));
		for (i = 0; i < len; i++) begin
			if (i == 0)
				fr.push_back(mtype[11:4]);
			else if (i == 1)
				fr.push_back({mtype[3:0], sub});
			else
				fr.push_back(8'($urandom));
		end
		c = '0;
		foreach (fr[j])
			c = crc24q_next(c, fr[j]);
		if (spoil)
			c = c ^ (24'd1 << $urandom_range(23));
		fr.push_back(c[23:16]);
		fr.push_back(c[15:8]);
		fr.push_back(c[7:0]);
		for (i = 0; i < fr.size() - cut; i++)
			send_byte(fr[i]);
	endtask

	task automatic send_ascii(input int unsigned body_len, input bit terminate);
		logic [7:0]  b;
		int unsigned i;
		send_text("#AP");
		for (i = 0; i < body_len; i++) begin
			if ($urandom_range(99) < 25)
				b = CHR_COMMA;
			else if ($urandom_range(99) < 4)
				b = 8'($urandom);
			else
				b = 8'($urandom_range(8'h20, 8'h7E));
			send_byte(b);
		end
		if (terminate) begin
			send_byte(CHR_STAR);
			send_byte(8'($urandom_range(8'h30, 8'h46)));
			send_byte(8'($urandom_range(8'h30, 8'h46)));
			send_byte($urandom_range(1) ? CHR_CR : CHR_LF);
		end
	endtask

	task automatic send_junk();
		logic [7:0] b;
		int unsigned sel;
		sel = $urandom_range(3);
		b   = 8'($urandom);
		if (sel == 0) begin
			repeat ($urandom_range(1, 5)) begin
				b = 8'($urandom);
				if (b == START_RTCM)
					b = 8'h00;
				send_byte(b);
			end
		end else if (sel == 1) begin
			send_byte(CHR_HASH);
			send_byte(b == CHR_A ? CHR_HASH : b);
		end else if (sel == 2) begin
			send_text("#A");
			send_byte(b == CHR_P ? CHR_A : b);
		end else begin
			send_rtcm($urandom_range(6), 12'($urandom), 4'($urandom), 1'b0,
				$urandom_range(1, 3));
		end
	endtask

	// wait until every byte in flight has its result, then leave the pipe settle
	task automatic wait_drained();
		rx_ch.valid = 1'b0;
		while (board.due_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_vendor_type(input logic [11:0] v);
		wait_drained();
		cfg_ch.valid           = 1'b1;
		cfg_ch.vendor_msg_type = v;
		do @(posedge clk); while (!cfg_ch.ready);
		@(negedge clk);
		cfg_ch.valid = 1'b0;
		vendor_now   = v;
	endtask

	initial begin
		logic [11:0] phase_types[5];
		int unsigned phase_start;
		int unsigned pick;
		int unsigned len;
		int p;

		clk                    = 1'b0;
		arst_n                 = 1'b0;
		rx_ch.valid            = 1'b0;
		rx_ch.rx_byte          = '0;
		res_ch.ready           = 1'b0;
		cfg_ch.valid           = 1'b0;
		cfg_ch.vendor_msg_type = '0;
		gaps_on                = 1'b1;
		cycles                 = 0;
		bytes_sent             = 0;
		vendor_now             = VENDOR_TYPE_RST;
		phase_types            = '{12'd0, 12'd4095, VENDOR_TYPE_RST, 12'd1005, 12'($urandom)};

		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: dropped starts, short and long frames, with the reset vendor type
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(CHR_A);
		send_text("##");
		send_text("#A#");
		send_text("#AP,x*4F\r");
		send_text("#AP*\r\n*00\n");
		send_rtcm(0, 12'd0, 4'd0, 1'b0, 0);
		send_rtcm(5, VENDOR_TYPE_RST, 4'hF, 1'b0, 0);
		send_rtcm(5, VENDOR_TYPE_RST, 4'hA, 1'b1, 0);
		send_rtcm(1, VENDOR_TYPE_RST, 4'h5, 1'b0, 0);
		send_rtcm(1023, 12'hFFF, 4'h0, 1'b0, 0);
		// separator count saturates
		send_text("#AP");
		repeat (70) send_byte(CHR_COMMA);
		send_text("*00\r");
		// sentence that fills the buffer, next byte is judged as a start
		send_text("#AP");
		repeat (FRAME_BUFFER_BYTES - 3) send_byte("x");
		send_text("#AP,*12\n");

		for (p = 0; p < 5; p++) begin
			write_vendor_type(phase_types[p]);
			gaps_on     = (p != 2);
			phase_start = bytes_sent;
			while (bytes_sent - phase_start < PHASE_BYTES) begin
				pick = $urandom_range(99);
				if (pick < 45) begin
					len = ($urandom_range(9) < 8) ? $urandom_range(24) : $urandom_range(200);
					send_rtcm(len, $urandom_range(1) ? vendor_now : 12'($urandom),
						4'($urandom), $urandom_range(9) == 0,
						($urandom_range(19) == 0) ? $urandom_range(1, 3) : 0);
				end else if (pick < 80) begin
					send_ascii($urandom_range(40), $urandom_range(9) != 0);
				end else begin
					send_junk();
				end
			end
		end
		gaps_on = 1'b1;

		wait_drained();
		repeat (8) @(posedge clk);
		if (board.mismatches == 0 && board.due_results.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/arfd_pkg.sv
rtl/core/arfd_if.sv
rtl/core/ascii_rtcm3_frame_detector_core.sv
tb/sv/tb_ascii_rtcm3_frame_detector_core.sv
